@@ rtl/core/kvt_pkg.sv @@
// Package for the key/value line tokenizer.
// Parse mode codes, character codes and field widths; no dependencies.
`default_nettype none
package kvt_pkg;

   localparam int MAX_BUFFER_BYTES_DEFAULT = 65536;
   localparam int OFFSET_W = 16;
   localparam int BYTE_W   = 8;
   localparam int MODE_W   = 3;

   localparam logic [MODE_W-1:0] MODE_SKIP_LINE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_KEY_START   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_KEY         = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SKIP_ARROW  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_VALUE_START = 3'd4;
   localparam logic [MODE_W-1:0] MODE_VALUE       = 3'd5;

   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

   localparam logic [1:0] ARROW_SKIP_COUNT = 2'd2;

endpackage
`default_nettype wire

@@ rtl/core/kvt_stream_if.sv @@
// Request and response channel interfaces of the key/value line tokenizer.
// Depends on kvt_pkg for the field widths.
`default_nettype none
interface kvt_req_if import kvt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] key_offset;
   logic [OFFSET_W-1:0] key_length;
   logic [OFFSET_W-1:0] value_offset;
   logic [OFFSET_W-1:0] value_length;

   modport source (output valid, output key_offset, output key_length,
                   output value_offset, output value_length, input ready);
   modport sink   (input valid, input key_offset, input key_length,
                   input value_offset, input value_length, output ready);
endinterface
`default_nettype wire

@@ rtl/core/key_value_line_tokenizer_top.sv @@
// Key/value line tokenizer, top level.
// Depends on kvt_pkg and the kvt_req_if / kvt_rsp_if channel interfaces.
//
// Scans a text buffer one byte per request and reports each "key => value"
// line as key and value offsets and lengths (16 bits, modulo 65536). The first
// line of every buffer is skipped; end_of_buffer on a byte returns the parser
// to its start state after that byte. One byte is accepted every cycle unless
// the response side stalls; a byte's response, if it has one, passes from the
// input register through the parser state update into the response register.
// Backpressure on the response side stalls the input register only when a
// response is held.
`default_nettype none
module key_value_line_tokenizer_top import kvt_pkg::*; #(
   parameter int MAX_BUFFER_BYTES = MAX_BUFFER_BYTES_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   kvt_req_if.sink   req_if,
   kvt_rsp_if.source rsp_if
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // parser state
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [OFFSET_W-1:0] key_start_ff, key_start_in;
   logic [OFFSET_W-1:0] key_end_ff, key_end_in;
   logic [OFFSET_W-1:0] value_start_ff, value_start_in;
   logic [1:0]          skip_ff, skip_in;
   logic                prev_space_ff, prev_space_in;

   // response register
   logic                rsp_valid_ff;
   logic [OFFSET_W-1:0] key_off_ff, key_len_ff, val_off_ff, val_len_ff;

   logic                out_free;
   logic                advance;
   logic                emit;
   logic                in_range;
   logic                is_nl;
   logic [OFFSET_W-1:0] pos16;
   logic [1:0]          skip_dec;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;

   generate
      if (POS_W >= OFFSET_W) begin : g_pos_trunc
         assign pos16 = pos_ff[OFFSET_W-1:0];
      end else begin : g_pos_ext
         assign pos16 = {{(OFFSET_W-POS_W){1'b0}}, pos_ff};
      end
   endgenerate

   assign in_range = pos_ff < POS_W'(MAX_BUFFER_BYTES);
   assign is_nl    = in_byte_ff == CH_NEWLINE;
   assign skip_dec = (skip_ff != 2'd0) ? skip_ff - 2'd1 : skip_ff;

   always_comb begin
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      key_start_in   = key_start_ff;
      key_end_in     = key_end_ff;
      value_start_in = value_start_ff;
      skip_in        = skip_ff;
      prev_space_in  = prev_space_ff;
      emit           = 1'b0;
      if (in_range) begin
         case (mode_ff)
            MODE_KEY_START: begin
               key_start_in = pos16;
               mode_in      = is_nl ? MODE_KEY_START : MODE_KEY;
            end
            MODE_KEY: begin
               if (in_byte_ff == CH_EQUALS) begin
                  key_end_in = prev_space_ff ? pos16 - OFFSET_W'(1) : pos16;
                  skip_in    = ARROW_SKIP_COUNT;
                  mode_in    = MODE_SKIP_ARROW;
               end else if (is_nl) begin
                  mode_in = MODE_KEY_START;
               end
            end
            MODE_SKIP_ARROW: begin
               skip_in = skip_dec;
               if (skip_dec == 2'd0) begin
                  mode_in = MODE_VALUE_START;
               end
            end
            MODE_VALUE_START: begin
               value_start_in = pos16;
               if (is_nl) begin
                  emit    = 1'b1;
                  mode_in = MODE_KEY_START;
               end else begin
                  mode_in = MODE_VALUE;
               end
            end
            MODE_VALUE: begin
               if (is_nl) begin
                  emit    = 1'b1;
                  mode_in = MODE_KEY_START;
               end
            end
            default: begin
               mode_in = is_nl ? MODE_KEY_START : MODE_SKIP_LINE;
            end
         endcase
         prev_space_in = in_byte_ff == CH_SPACE;
         pos_in        = pos_ff + POS_W'(1);
      end
      if (in_last_ff) begin
         mode_in       = MODE_SKIP_LINE;
         pos_in        = '0;
         skip_in       = 2'd0;
         prev_space_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_SKIP_LINE;
         pos_ff         <= '0;
         key_start_ff   <= '0;
         key_end_ff     <= '0;
         value_start_ff <= '0;
         skip_ff        <= 2'd0;
         prev_space_ff  <= 1'b0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            mode_ff        <= mode_in;
            pos_ff         <= pos_in;
            key_start_ff   <= key_start_in;
            key_end_ff     <= key_end_in;
            value_start_ff <= value_start_in;
            skip_ff        <= skip_in;
            prev_space_ff  <= prev_space_in;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.end_of_buffer;
      end
      if (advance && emit) begin
         key_off_ff <= key_start_ff;
         key_len_ff <= key_end_ff - key_start_ff;
         val_off_ff <= value_start_in;
         val_len_ff <= pos16 - value_start_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.key_offset   = key_off_ff;
   assign rsp_if.key_length   = key_len_ff;
   assign rsp_if.value_offset = val_off_ff;
   assign rsp_if.value_length = val_len_ff;

endmodule
`default_nettype wire

@@ verif/tb_key_value_line_tokenizer_top.sv @@
// Testbench for key_value_line_tokenizer_top: drives byte requests, predicts the
// key/value spans locally and checks every response in order.
// Depends on kvt_pkg, kvt_req_if / kvt_rsp_if and the tokenizer RTL.
`timescale 1ns / 1ps
module tb_key_value_line_tokenizer_top;
   import kvt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [OFFSET_W-1:0] key_offset;
      logic [OFFSET_W-1:0] key_length;
      logic [OFFSET_W-1:0] value_offset;
      logic [OFFSET_W-1:0] value_length;
   } kv_span_type;

   logic clock;
   logic reset;

   kvt_req_if req ();
   kvt_rsp_if rsp ();

   key_value_line_tokenizer_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   kv_span_type       expected_spans[$];
   logic [BYTE_W-1:0] buffer_text[$];
   int                mismatches = 0;
   int                items_sent = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                rsp_hold_cycles = 0;

   // parser state mirror
   logic [MODE_W-1:0] scan_mode;
   int unsigned       scan_pos;
   int unsigned       key_start;
   int unsigned       key_end;
   int unsigned       value_start;
   logic [1:0]        arrow_left;
   bit                after_space;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic clear_scan();
      scan_mode   = MODE_SKIP_LINE;
      scan_pos    = 0;
      arrow_left  = '0;
      after_space = 1'b0;
   endtask

   task automatic tokenize_byte(input logic [BYTE_W-1:0] b, input bit end_mark);
      int unsigned at;
      kv_span_type span;
      at = scan_pos;
      if (at < MAX_BUFFER_BYTES_DEFAULT) begin
         case (scan_mode)
            MODE_KEY_START: begin
               key_start = at;
               scan_mode = (b == CH_NEWLINE) ? MODE_KEY_START : MODE_KEY;
            end
            MODE_KEY: begin
               if (b == CH_EQUALS) begin
                  key_end    = after_space ? at - 1 : at;
                  arrow_left = ARROW_SKIP_COUNT;
                  scan_mode  = MODE_SKIP_ARROW;
               end else if (b == CH_NEWLINE) begin
                  scan_mode = MODE_KEY_START;
               end
            end
            MODE_SKIP_ARROW: begin
               if (arrow_left > 0) arrow_left--;
               if (arrow_left == 0) scan_mode = MODE_VALUE_START;
            end
            MODE_VALUE_START, MODE_VALUE: begin
               if (scan_mode == MODE_VALUE_START) value_start = at;
               if (b == CH_NEWLINE) begin
                  span.key_offset   = key_start[OFFSET_W-1:0];
                  span.key_length   = OFFSET_W'(key_end - key_start);
                  span.value_offset = value_start[OFFSET_W-1:0];
                  span.value_length = OFFSET_W'(at - value_start);
                  expected_spans.push_back(span);
                  scan_mode = MODE_KEY_START;
               end else begin
                  scan_mode = MODE_VALUE;
               end
            end
            default: begin
               scan_mode = (b == CH_NEWLINE) ? MODE_KEY_START : MODE_SKIP_LINE;
            end
         endcase
         after_space = (b == CH_SPACE);
         scan_pos    = at + 1;
      end
      if (end_mark) clear_scan();
   endtask

   task automatic check_field(input string name, input logic [OFFSET_W-1:0] want,
                              input logic [OFFSET_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_response
      kv_span_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_spans.size() == 0) begin
            $error("key_offset: expected no response, got %0d", rsp.key_offset);
            mismatches++;
         end else begin
            want = expected_spans.pop_front();
            check_field("key_offset", want.key_offset, rsp.key_offset);
            check_field("key_length", want.key_length, rsp.key_length);
            check_field("value_offset", want.value_offset, rsp.value_offset);
            check_field("value_length", want.value_length, rsp.value_length);
         end
      end
   end

   // response ready, with an optional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_request(input logic [BYTE_W-1:0] b, input bit end_mark);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.data_byte     <= b;
      req.end_of_buffer <= end_mark;
      do @(posedge clock); while (!req.ready);
      tokenize_byte(b, end_mark);
      items_sent++;
   endtask

   task automatic send_buffer();
      foreach (buffer_text[i]) send_request(buffer_text[i], i == buffer_text.size() - 1);
      buffer_text.delete();
   endtask

   function automatic logic [BYTE_W-1:0] rand_text_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_NEWLINE || b == CH_EQUALS);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_any_byte();
      case ($urandom_range(0, 7))
         0: return CH_NEWLINE;
         1: return CH_EQUALS;
         2: return CH_SPACE;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) buffer_text.push_back(s[i]);
   endtask

   // one "key => value" line; arrow bytes are occasionally garbage
   task automatic push_line(input int key_len, input int value_len);
      repeat (key_len) buffer_text.push_back(rand_text_byte());
      if ($urandom_range(0, 1)) buffer_text.push_back(CH_SPACE);
      buffer_text.push_back(CH_EQUALS);
      if ($urandom_range(0, 7) == 0) begin
         buffer_text.push_back(rand_any_byte());
         buffer_text.push_back(rand_any_byte());
      end else begin
         push_string("> ");
      end
      repeat (value_len) buffer_text.push_back(rand_text_byte());
      buffer_text.push_back(CH_NEWLINE);
   endtask

   // skipped first line, blank line, restarted key, empty value,
   // extreme bytes, unfinished value at end of buffer
   task automatic test_directed_lines();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      push_string("#=\n\na\nk => \n");
      buffer_text.push_back(8'hFF);
      push_string("=> ");
      buffer_text.push_back(8'h00);
      push_string("\nq =>zz");
      send_buffer();
   endtask

   // a long key, then a long value
   task automatic test_long_fields();
      for (int pass = 0; pass < 2; pass++) begin
         buffer_text.push_back(CH_NEWLINE);
         repeat (pass == 0 ? 40 : 3) buffer_text.push_back(rand_text_byte());
         push_string(" => ");
         repeat (pass == 0 ? 8 : 45) buffer_text.push_back(rand_text_byte());
         buffer_text.push_back(CH_NEWLINE);
         push_line($urandom_range(1, 4), $urandom_range(0, 6));
         send_buffer();
      end
   endtask

   task automatic test_response_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(negedge clock);
      req.valid <= 1'b0;
      rsp_hold_cycles = 400;
      buffer_text.push_back(CH_NEWLINE);
      repeat (30) push_string("k => v\n");
      send_buffer();
   endtask

   task automatic test_random_buffers(input int idle_pct, input int stall_pct);
      int goal;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal = items_sent + 240;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 30)) buffer_text.push_back(rand_any_byte());
         end else begin
            repeat ($urandom_range(0, 5)) buffer_text.push_back(rand_text_byte());
            buffer_text.push_back(CH_NEWLINE);
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 5) == 0) begin
                  repeat ($urandom_range(0, 3)) buffer_text.push_back(rand_text_byte());
                  buffer_text.push_back(CH_NEWLINE);
               end
               push_line($urandom_range(1, 6), $urandom_range(0, 8));
            end
            // cut the buffer short now and then
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(0, buffer_text.size() - 1)) void'(buffer_text.pop_back());
         end
         send_buffer();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.data_byte     = '0;
      req.end_of_buffer = 1'b0;
      rsp.ready         = 1'b0;
      clear_scan();
      key_start   = 0;
      key_end     = 0;
      value_start = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_long_fields();
      test_response_backpressure();
      test_random_buffers(0, 0);
      test_random_buffers(45, 0);
      test_random_buffers(0, 45);
      test_random_buffers(17, 17);

      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ key_value_line_tokenizer_top.f @@
rtl/core/kvt_pkg.sv
rtl/core/kvt_stream_if.sv
rtl/core/key_value_line_tokenizer_top.sv
verif/tb_key_value_line_tokenizer_top.sv
